// ===== sv/modbus_serial_response_checker_assert.svh =====
// Assertion macros used by the checker file of the response checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MODBUS_SERIAL_RESPONSE_CHECKER_ASSERT_SVH
`define MODBUS_SERIAL_RESPONSE_CHECKER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define MRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define MRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mrc_pkg.sv =====
// Package for the Modbus serial response checker: item types, status codes,
// character constants, CRC-16 and hex decode helpers. No dependencies.
`timescale 1ns / 1ps

package mrc_pkg;

    localparam int MAX_FRAME_CHARS_DEF = 1000;
    localparam int Q_DEPTH             = 4;

    localparam logic [7:0]  CHAR_COLON = 8'h3A;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic KIND_PDU     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_CRC       = 3'd2,
        ST_FORMAT    = 3'd3,
        ST_LRC       = 3'd4,
        ST_EXCEPTION = 3'd5
    } mrc_status_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  pdu_byte;
        logic        is_last;
        mrc_status_t status;
        logic [6:0]  function_code;
        logic [7:0]  exception_code;
    } mrc_item_t;

    typedef struct packed {
        logic      pdu_valid;
        mrc_item_t pdu_item;
        logic      verdict_valid;
        mrc_item_t verdict_item;
    } mrc_step_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

endpackage

// ===== sv/mrc_rx_if.sv =====
// Input channel of the response checker: one received character per beat.
// No dependencies.
`timescale 1ns / 1ps

interface mrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, rx_byte, frame_end, input ready);
    modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

// ===== sv/mrc_res_if.sv =====
// Result channel of the response checker: one PDU byte or verdict per beat.
// No dependencies.
`timescale 1ns / 1ps

interface mrc_res_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] pdu_byte;
    logic       is_last;
    logic [2:0] status;
    logic [6:0] function_code;
    logic [7:0] exception_code;

    modport source (output valid, item_kind, pdu_byte, is_last, status,
                    function_code, exception_code, input ready);
    modport sink   (input valid, item_kind, pdu_byte, is_last, status,
                    function_code, exception_code, output ready);
endinterface

// ===== sv/mrc_core.sv =====
// Per-character frame logic: CRC/LRC, hex pairing, PDU delay line, verdict.
// Depends on mrc_pkg.
`timescale 1ns / 1ps

module mrc_core
    import mrc_pkg::*;
#(
    parameter int MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] rx_byte,
    input  logic       frame_end,
    input  logic       frame_mode,
    output mrc_step_t  step_res
);

    localparam int CntW = $clog2(MAX_FRAME_CHARS + 1);
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME_CHARS);

    logic [CntW-1:0] cnt_reg,  cnt_next;
    logic [CntW-1:0] dc_reg,   dc_next;
    logic [15:0]     crc_reg,  crc_next;
    logic [7:0]      lrc_reg,  lrc_next;
    logic [3:0]      hn_reg,   hn_next;
    logic            np_reg,   np_next;
    logic [7:0]      d0_reg,   d0_next;
    logic [7:0]      d1_reg,   d1_next;
    logic [7:0]      f0_reg,   f0_next;
    logic [7:0]      f1_reg,   f1_next;
    logic            fb_reg,   fb_next;
    logic [7:0]      lc_reg,   lc_next;

    logic            pdu_emit;
    logic [7:0]      pdu_val;
    logic [7:0]      cand;
    logic            len_ge1;
    logic            len_ge2;
    mrc_status_t     status;

    always_comb
    begin
        cnt_next = cnt_reg;
        dc_next  = dc_reg;
        crc_next = crc_reg;
        lrc_next = lrc_reg;
        hn_next  = hn_reg;
        np_next  = np_reg;
        d0_next  = d0_reg;
        d1_next  = d1_reg;
        f0_next  = f0_reg;
        f1_next  = f1_reg;
        fb_next  = fb_reg;
        lc_next  = lc_reg;
        pdu_emit = 1'b0;
        pdu_val  = 8'h00;
        cand     = 8'h00;
        len_ge1  = 1'b0;
        len_ge2  = 1'b0;
        status   = ST_OK;

        if (step_en)
        begin
            if (cnt_reg < CntMax)
            begin
                if (!frame_mode)
                begin
                    crc_next = crc16_byte(crc_reg, rx_byte);
                    if (cnt_reg >= CntW'(3))
                    begin
                        pdu_emit = 1'b1;
                        pdu_val  = d1_reg;
                        if (cnt_reg == CntW'(3))
                        begin
                            f0_next = d1_reg;
                        end
                        if (cnt_reg == CntW'(4))
                        begin
                            f1_next = d1_reg;
                        end
                    end
                    d1_next = d0_reg;
                    d0_next = rx_byte;
                end
                else if (cnt_reg == '0)
                begin
                    if (rx_byte != CHAR_COLON)
                    begin
                        fb_next = 1'b1;
                    end
                end
                else if (cnt_reg[0])
                begin
                    hn_next = hex_value(rx_byte);
                    np_next = 1'b1;
                end
                else
                begin
                    cand    = {(np_reg ? hn_reg : 4'h0), hex_value(rx_byte)};
                    np_next = 1'b0;
                    if (cnt_reg >= CntW'(4))
                    begin
                        lrc_next = lrc_reg + d0_reg;
                        if (dc_reg >= CntW'(2))
                        begin
                            pdu_emit = 1'b1;
                            pdu_val  = d1_reg;
                            if (dc_reg == CntW'(2))
                            begin
                                f0_next = d1_reg;
                            end
                            if (dc_reg == CntW'(3))
                            begin
                                f1_next = d1_reg;
                            end
                        end
                        d1_next = d0_reg;
                        dc_next = dc_reg + 1'b1;
                    end
                    d0_next = cand;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                fb_next = 1'b1;
            end

            if (frame_end)
            begin
                if (!frame_mode)
                begin
                    len_ge1 = cnt_next >= CntW'(4);
                    len_ge2 = cnt_next >= CntW'(5);
                    priority if (fb_next)
                        status = ST_FORMAT;
                    else if (cnt_next < CntW'(2))
                        status = ST_SHORT;
                    else if (crc_next != 16'h0000)
                        status = ST_CRC;
                    else
                        status = ST_OK;
                end
                else
                begin
                    len_ge1 = dc_next >= CntW'(3);
                    len_ge2 = dc_next >= CntW'(4);
                    priority if (cnt_next < CntW'(3) || fb_next || lc_reg != CHAR_CR
                                 || rx_byte != CHAR_LF)
                        status = ST_FORMAT;
                    else if (lrc_next != 8'h00)
                        status = ST_LRC;
                    else
                        status = ST_OK;
                end
                if (status == ST_OK)
                begin
                    priority if (!len_ge2)
                        status = ST_SHORT;
                    else if (f0_next[7])
                        status = ST_EXCEPTION;
                    else
                        status = ST_OK;
                end
            end
        end

        step_res.pdu_valid                   = pdu_emit;
        step_res.pdu_item.item_kind          = KIND_PDU;
        step_res.pdu_item.pdu_byte           = pdu_val;
        step_res.pdu_item.is_last            = 1'b0;
        step_res.pdu_item.status             = ST_OK;
        step_res.pdu_item.function_code      = 7'h00;
        step_res.pdu_item.exception_code     = 8'h00;
        step_res.verdict_valid               = step_en && frame_end;
        step_res.verdict_item.item_kind      = KIND_VERDICT;
        step_res.verdict_item.pdu_byte       = 8'h00;
        step_res.verdict_item.is_last        = 1'b1;
        step_res.verdict_item.status         = status;
        step_res.verdict_item.function_code  = len_ge1 ? f0_next[6:0] : 7'h00;
        step_res.verdict_item.exception_code =
            (status == ST_EXCEPTION) ? f1_next : 8'h00;

        if (step_en)
        begin
            if (frame_end)
            begin
                cnt_next = '0;
                dc_next  = '0;
                crc_next = CRC_INIT;
                lrc_next = 8'h00;
                hn_next  = 4'h0;
                np_next  = 1'b0;
                d0_next  = 8'h00;
                d1_next  = 8'h00;
                f0_next  = 8'h00;
                f1_next  = 8'h00;
                fb_next  = 1'b0;
                lc_next  = 8'h00;
            end
            else
            begin
                lc_next = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            dc_reg  <= '0;
            crc_reg <= CRC_INIT;
            lrc_reg <= 8'h00;
            hn_reg  <= 4'h0;
            np_reg  <= 1'b0;
            d0_reg  <= 8'h00;
            d1_reg  <= 8'h00;
            f0_reg  <= 8'h00;
            f1_reg  <= 8'h00;
            fb_reg  <= 1'b0;
            lc_reg  <= 8'h00;
        end
        else
        begin
            cnt_reg <= cnt_next;
            dc_reg  <= dc_next;
            crc_reg <= crc_next;
            lrc_reg <= lrc_next;
            hn_reg  <= hn_next;
            np_reg  <= np_next;
            d0_reg  <= d0_next;
            d1_reg  <= d1_next;
            f0_reg  <= f0_next;
            f1_reg  <= f1_next;
            fb_reg  <= fb_next;
            lc_reg  <= lc_next;
        end
    end

endmodule

// ===== sv/modbus_serial_response_checker.sv =====
// Modbus serial response checker, top level: input register, frame logic, result queue.
// Throughput: one character per cycle while the result queue holds at most two entries;
// the four-entry result queue absorbs the second result of a frame's last character,
// and one result leaves per cycle while res.ready is high.
// Reset: rst_n clears frame state, the mode register (RTU) and the queue at once.
`timescale 1ns / 1ps

module modbus_serial_response_checker
    import mrc_pkg::*;
#(
    parameter int MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic     cfg_data,
    mrc_rx_if.sink   rx,
    mrc_res_if.source res
);

    localparam int QPtrW = $clog2(Q_DEPTH);
    localparam int QCntW = $clog2(Q_DEPTH + 1);

    logic              mode_reg;
    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic              s1_end_reg;
    logic              proc;
    logic              pop;
    mrc_step_t         step_res;
    mrc_item_t         q_mem [Q_DEPTH];
    logic [QPtrW-1:0]  wr_ptr_reg;
    logic [QPtrW-1:0]  rd_ptr_reg;
    logic [QCntW-1:0]  q_cnt_reg;
    logic [1:0]        push_n;
    mrc_item_t         item0;
    mrc_item_t         head;

    assign proc     = s1_valid_reg && (q_cnt_reg <= QCntW'(Q_DEPTH - 2));
    assign rx.ready = !s1_valid_reg || proc;
    assign pop      = res.valid && res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (rx.valid && rx.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
            s1_end_reg  <= rx.frame_end;
        end
    end

    mrc_core #(
        .MAX_FRAME_CHARS (MAX_FRAME_CHARS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (proc),
        .rx_byte    (s1_byte_reg),
        .frame_end  (s1_end_reg),
        .frame_mode (mode_reg),
        .step_res   (step_res)
    );

    assign push_n = 2'(step_res.pdu_valid) + 2'(step_res.verdict_valid);
    assign item0  = step_res.pdu_valid ? step_res.pdu_item : step_res.verdict_item;

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            q_mem[wr_ptr_reg] <= item0;
        end
        if (push_n == 2'd2)
        begin
            q_mem[QPtrW'(wr_ptr_reg + 1'b1)] <= step_res.verdict_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= QPtrW'(wr_ptr_reg + push_n);
            rd_ptr_reg <= QPtrW'(rd_ptr_reg + pop);
            q_cnt_reg  <= QCntW'(q_cnt_reg + push_n - pop);
        end
    end

    assign head               = q_mem[rd_ptr_reg];
    assign res.valid          = q_cnt_reg != '0;
    assign res.item_kind      = head.item_kind;
    assign res.pdu_byte       = head.pdu_byte;
    assign res.is_last        = head.is_last;
    assign res.status         = head.status;
    assign res.function_code  = head.function_code;
    assign res.exception_code = head.exception_code;

endmodule

// ===== sv/mrc_checker.sv =====
// Port-level assertions for the response checker, bound to the top level.
// Depends on mrc_pkg and modbus_serial_response_checker_assert.svh.
`timescale 1ns / 1ps
`include "modbus_serial_response_checker_assert.svh"

module mrc_checker
    import mrc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic       item_kind,
    input logic [7:0] pdu_byte,
    input logic       is_last,
    input logic [2:0] status,
    input logic [6:0] function_code,
    input logic [7:0] exception_code
);

    `MRC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable(item_kind) && $stable(pdu_byte) && $stable(status)
        && $stable(exception_code), "result beat changed while stalled")
    `MRC_ASSERT_NOW(a_verdict_shape, res_valid && item_kind == KIND_VERDICT,
        is_last && pdu_byte == 8'h00, "verdict beat malformed")
    `MRC_ASSERT_NOW(a_pdu_shape, res_valid && item_kind == KIND_PDU,
        !is_last && status == ST_OK && function_code == 7'h00
        && exception_code == 8'h00, "PDU beat malformed")
    `MRC_ASSERT_NOW(a_status_range, res_valid, status <= ST_EXCEPTION,
        "status code out of range")
    `MRC_ASSERT_NOW(a_exc_code, res_valid && exception_code != 8'h00,
        status == ST_EXCEPTION, "exception code without exception status")

endmodule

bind modbus_serial_response_checker mrc_checker u_mrc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .item_kind      (res.item_kind),
    .pdu_byte       (res.pdu_byte),
    .is_last        (res.is_last),
    .status         (res.status),
    .function_code  (res.function_code),
    .exception_code (res.exception_code)
);

// ===== test/tb_modbus_serial_response_checker.sv =====
// Testbench for modbus_serial_response_checker: RTU and ASCII response frames,
// with every result checked against a built-in frame predictor.
// Depends on mrc_pkg, mrc_rx_if, mrc_res_if and the checker RTL.
`timescale 1ns / 1ps

module tb_modbus_serial_response_checker;
    import mrc_pkg::*;

    localparam int FRAME_CHAR_LIMIT = MAX_FRAME_CHARS_DEF;
    localparam int RANDOM_CHARS     = 600;
    localparam int LATENCY_PAUSE    = 4;
    localparam int WATCHDOG_CYCLES  = 2000;
    localparam int IDLE_PERCENT     = 7;

    typedef enum int {
        FLAW_NONE,
        FLAW_CHECK,
        FLAW_TRUNCATED,
        FLAW_BAD_DIGIT,
        FLAW_LOWER_HEX,
        FLAW_ODD_BODY,
        FLAW_NO_COLON,
        FLAW_NO_CRLF,
        FLAW_NOISE
    } frame_flaw_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    mrc_rx_if  rx_ch();
    mrc_res_if res_ch();

    modbus_serial_response_checker dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .rx       (rx_ch),
        .res      (res_ch)
    );

    mrc_item_t  results_due[$];
    logic [7:0] frame_chars[$];
    logic [7:0] body[$];
    int         mismatch_count;
    int         chars_sent;
    int         stuck_cycles;
    bit         no_stall;

    // frame predictor state
    bit         ascii_mode;
    logic [9:0] rx_chars;
    logic [15:0] crc_acc;
    logic [7:0] lrc_acc;
    logic [3:0] hi_nib;
    bit         nib_pend;
    logic [7:0] held[2];
    logic [9:0] dec_cnt;
    logic [7:0] first_pdu[2];
    bit         fmt_bad;
    logic [7:0] prev_char;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc_in,
                                                      input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            acc = acc[0] ? ((acc >> 1) ^ 16'hA001) : (acc >> 1);
        end
        return acc;
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
        logic [3:0] v;
        v = 4'h0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            v = 4'(ch - 8'h30);
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            v = 4'(ch - 8'h37);
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h37 + 8'(nib);
    endfunction

    function automatic bit hold_off();
        return !no_stall && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    task automatic clear_frame_state();
        rx_chars     = '0;
        crc_acc      = CRC_INIT;
        lrc_acc      = '0;
        hi_nib       = '0;
        nib_pend     = 1'b0;
        held[0]      = '0;
        held[1]      = '0;
        dec_cnt      = '0;
        first_pdu[0] = '0;
        first_pdu[1] = '0;
        fmt_bad      = 1'b0;
        prev_char    = '0;
    endtask

    task automatic note_pdu_byte(input logic [7:0] b, input logic [9:0] idx);
        mrc_item_t it;
        if (idx < 2)
        begin
            first_pdu[idx[0]] = b;
        end
        it = '0;
        it.item_kind = KIND_PDU;
        it.pdu_byte  = b;
        it.status    = ST_OK;
        results_due.push_back(it);
    endtask

    task automatic track_response_char(input logic [7:0] c, input logic last);
        logic [9:0]  i;
        logic [3:0]  hi;
        logic [7:0]  cand;
        logic [9:0]  pdu_len;
        mrc_status_t st;
        mrc_item_t   v;
        if (rx_chars < FRAME_CHAR_LIMIT)
        begin
            i = rx_chars;
            if (!ascii_mode)
            begin
                crc_acc = crc16_modbus_step(crc_acc, c);
                if (i >= 3)
                begin
                    note_pdu_byte(held[1], i - 10'd3);
                end
                held[1] = held[0];
                held[0] = c;
            end
            else if (i == 0)
            begin
                if (c != CHAR_COLON)
                begin
                    fmt_bad = 1'b1;
                end
            end
            else if (i[0])
            begin
                hi_nib   = hex_nibble(c);
                nib_pend = 1'b1;
            end
            else
            begin
                hi       = nib_pend ? hi_nib : 4'h0;
                cand     = {hi, hex_nibble(c)};
                nib_pend = 1'b0;
                if (i >= 4)
                begin
                    lrc_acc = lrc_acc + held[0];
                    if (dec_cnt >= 2)
                    begin
                        note_pdu_byte(held[1], dec_cnt - 10'd2);
                    end
                    held[1] = held[0];
                    dec_cnt = dec_cnt + 10'd1;
                end
                held[0] = cand;
            end
            rx_chars = i + 10'd1;
        end
        else
        begin
            fmt_bad = 1'b1;
        end

        if (last)
        begin
            if (!ascii_mode)
            begin
                pdu_len = (rx_chars >= 3) ? rx_chars - 10'd3 : '0;
                if (fmt_bad)
                    st = ST_FORMAT;
                else if (rx_chars < 2)
                    st = ST_SHORT;
                else if (crc_acc != 16'h0000)
                    st = ST_CRC;
                else
                    st = ST_OK;
            end
            else
            begin
                pdu_len = (dec_cnt >= 2) ? dec_cnt - 10'd2 : '0;
                if (rx_chars < 3 || fmt_bad || prev_char != CHAR_CR || c != CHAR_LF)
                    st = ST_FORMAT;
                else if (lrc_acc != 8'h00)
                    st = ST_LRC;
                else
                    st = ST_OK;
            end
            if (st == ST_OK)
            begin
                if (pdu_len < 2)
                    st = ST_SHORT;
                else if (first_pdu[0][7])
                    st = ST_EXCEPTION;
            end
            v                = '0;
            v.item_kind      = KIND_VERDICT;
            v.is_last        = 1'b1;
            v.status         = st;
            v.function_code  = (pdu_len >= 1) ? first_pdu[0][6:0] : 7'h00;
            v.exception_code = (st == ST_EXCEPTION) ? first_pdu[1] : 8'h00;
            results_due.push_back(v);
            clear_frame_state();
        end
        else if (rx_chars <= FRAME_CHAR_LIMIT)
        begin
            prev_char = c;
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        @(negedge clk);
        while (hold_off())
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid     <= 1'b1;
        rx_ch.rx_byte   <= c;
        rx_ch.frame_end <= last;
        @(posedge clk);
        while (!rx_ch.ready)
        begin
            @(posedge clk);
        end
        track_response_char(c, last);
        chars_sent++;
    endtask

    task automatic send_chars(input bit close);
        for (int k = 0; k < frame_chars.size(); k++)
        begin
            send_char(frame_chars[k], close && (k == frame_chars.size() - 1));
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    task automatic set_mode(input bit m);
        drain_results();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        ascii_mode = m;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic make_body();
        int n;
        body.delete();
        body.push_back(8'($urandom));
        n = ($urandom_range(99) < 85) ? $urandom_range(2, 10) : $urandom_range(0, 1);
        for (int k = 0; k < n; k++)
        begin
            body.push_back(8'($urandom));
        end
        if (n > 0)
        begin
            body[1][7] = ($urandom_range(99) < 25);
        end
    endtask

    task automatic frame_rtu(input frame_flaw_t flaw);
        logic [15:0] crc;
        int          pos;
        int          cut;
        crc = CRC_INIT;
        frame_chars = body;
        foreach (body[k])
        begin
            crc = crc16_modbus_step(crc, body[k]);
        end
        frame_chars.push_back(crc[7:0]);
        frame_chars.push_back(crc[15:8]);
        case (flaw)
            FLAW_CHECK:
            begin
                pos = $urandom_range(frame_chars.size() - 1);
                frame_chars[pos] = frame_chars[pos] ^ (8'h01 << $urandom_range(7));
            end
            FLAW_TRUNCATED:
            begin
                cut = $urandom_range(1, frame_chars.size() - 1);
                repeat (cut) frame_chars.delete(frame_chars.size() - 1);
            end
            default: ;
        endcase
    endtask

    task automatic frame_ascii(input frame_flaw_t flaw);
        logic [7:0] sum;
        logic [7:0] lrc;
        int         pos;
        int         cut;
        sum = '0;
        frame_chars.delete();
        frame_chars.push_back(CHAR_COLON);
        foreach (body[k])
        begin
            sum = sum + body[k];
            frame_chars.push_back(hex_digit(body[k][7:4]));
            frame_chars.push_back(hex_digit(body[k][3:0]));
        end
        lrc = 8'(-sum);
        if (flaw == FLAW_CHECK)
        begin
            lrc = lrc + 8'($urandom_range(1, 255));
        end
        frame_chars.push_back(hex_digit(lrc[7:4]));
        frame_chars.push_back(hex_digit(lrc[3:0]));
        frame_chars.push_back(CHAR_CR);
        frame_chars.push_back(CHAR_LF);
        pos = $urandom_range(1, frame_chars.size() - 3);
        case (flaw)
            FLAW_BAD_DIGIT: frame_chars[pos] = 8'($urandom);
            FLAW_LOWER_HEX: frame_chars[pos] = 8'h61 + 8'($urandom_range(5));
            FLAW_ODD_BODY:
                frame_chars.insert(frame_chars.size() - 2, hex_digit(4'($urandom)));
            FLAW_NO_COLON:  frame_chars[0] = 8'($urandom);
            FLAW_NO_CRLF:
            begin
                if ($urandom_range(1))
                    frame_chars.delete(frame_chars.size() - 1);
                else
                    frame_chars[frame_chars.size() - 2 + $urandom_range(1)] = 8'($urandom);
            end
            FLAW_TRUNCATED:
            begin
                cut = $urandom_range(1, frame_chars.size() - 1);
                repeat (cut) frame_chars.delete(frame_chars.size() - 1);
            end
            default: ;
        endcase
    endtask

    task automatic frame_noise();
        frame_chars.delete();
        repeat ($urandom_range(1, 8)) frame_chars.push_back(8'($urandom));
    endtask

    task automatic test_rtu_basics();
        set_mode(1'b0);
        body = '{8'h00, 8'h03, 8'hFF};
        frame_rtu(FLAW_NONE);
        send_chars(1'b1);
        frame_chars = '{8'hFF};
        send_chars(1'b1);
        frame_chars = '{8'h11, 8'h22};
        send_chars(1'b1);
        body = '{8'hFF, 8'h83, 8'h02};
        frame_rtu(FLAW_NONE);
        send_chars(1'b1);
    endtask

    task automatic test_ascii_basics();
        set_mode(1'b1);
        body = '{8'h01, 8'h03, 8'h00};
        frame_ascii(FLAW_NONE);
        send_chars(1'b1);
        frame_chars = '{CHAR_COLON, CHAR_CR, CHAR_LF};
        send_chars(1'b1);
    endtask

    task automatic test_mode_switch_mid_frame();
        set_mode(1'b0);
        frame_chars = '{8'h01, 8'h04, 8'h02};
        send_chars(1'b0);
        set_mode(1'b1);
        frame_chars = '{8'h31, 8'h32, 8'h41, 8'h46, 8'h30, 8'h39, CHAR_CR, CHAR_LF};
        send_chars(1'b1);
        frame_chars = '{CHAR_COLON, 8'h30, 8'h31};
        send_chars(1'b0);
        set_mode(1'b0);
        frame_chars = '{8'h03, 8'h02, 8'hAB, 8'hCD};
        send_chars(1'b1);
    endtask

    task automatic test_overlong_frames();
        set_mode(1'b0);
        frame_chars.delete();
        repeat (FRAME_CHAR_LIMIT - 4) frame_chars.push_back(8'($urandom));
        send_chars(1'b0);
        set_mode(1'b1);
        frame_chars = '{8'h31, 8'h32, 8'h41, 8'h46, 8'h30, 8'h39, CHAR_CR, CHAR_LF};
        send_chars(1'b1);
    endtask

    task automatic test_random_traffic();
        int          start;
        frame_flaw_t flaw;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS)
        begin
            no_stall = (chars_sent - start >= 200) && (chars_sent - start < 450);
            if ($urandom_range(99) < 15)
            begin
                set_mode(!ascii_mode);
            end
            make_body();
            flaw = FLAW_NONE;
            if ($urandom_range(99) >= 70)
            begin
                flaw = frame_flaw_t'($urandom_range(int'(FLAW_CHECK), int'(FLAW_NOISE)));
            end
            if (flaw == FLAW_NOISE)
                frame_noise();
            else if (ascii_mode)
                frame_ascii(flaw);
            else
                frame_rtu(flaw);
            send_chars(1'b1);
        end
        no_stall = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input mrc_item_t want,
                                   input mrc_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t %0s: expected kind=%0d byte=%02h last=%0d st=%0d fc=%02h exc=%02h",
                     $realtime, what, want.item_kind, want.pdu_byte, want.is_last,
                     want.status, want.function_code, want.exception_code);
            $display("%0t %0s:   actual kind=%0d byte=%02h last=%0d st=%0d fc=%02h exc=%02h",
                     $realtime, what, got.item_kind, got.pdu_byte, got.is_last,
                     got.status, got.function_code, got.exception_code);
        end
    endtask

    always @(posedge clk)
    begin
        mrc_item_t got;
        mrc_item_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.item_kind      = res_ch.item_kind;
            got.pdu_byte       = res_ch.pdu_byte;
            got.is_last        = res_ch.is_last;
            got.status         = mrc_status_t'(res_ch.status);
            got.function_code  = res_ch.function_code;
            got.exception_code = res_ch.exception_code;
            if (results_due.size() == 0)
            begin
                report_mismatch("unexpected beat", '0, got);
            end
            else
            begin
                want = results_due.pop_front();
                if (got.item_kind !== want.item_kind || got.pdu_byte !== want.pdu_byte ||
                    got.is_last !== want.is_last || got.status !== want.status ||
                    got.function_code !== want.function_code ||
                    got.exception_code !== want.exception_code)
                begin
                    report_mismatch("mismatch", want, got);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        res_ch.ready <= !hold_off();
    end

    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = 1'b0;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = 8'h00;
        rx_ch.frame_end = 1'b0;
        res_ch.ready    = 1'b0;
        mismatch_count  = 0;
        chars_sent      = 0;
        stuck_cycles    = 0;
        no_stall        = 1'b0;
        ascii_mode      = 1'b0;
        clear_frame_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_rtu_basics();
        test_ascii_basics();
        test_mode_switch_mid_frame();
        test_overlong_frames();
        test_random_traffic();

        drain_results();
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
